FILE: hw/rtl/i2c_master_register_access_macros.svh
// Assertion macros shared by the register-access I2C master RTL.
`ifndef I2C_MASTER_REGISTER_ACCESS_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_MACROS_SVH

// Same-cycle implication on i_clk, disabled while i_rst_n is low.
`define I2CM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, disabled while i_rst_n is low.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/i2cm_pkg.sv
// Package with codes, widths and types of the register-access I2C master.
`default_nettype none
package i2cm_pkg;

    // Read length limits
    localparam int RD_LEN_W       = 9;
    localparam int MAX_READ_BYTES = 256;

    // Configuration register indexes
    localparam int               CFG_IDX_W     = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_ADDR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WR_VALUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_LEN   = 3'd4;
    localparam int                   CFG_DATA_W   = 16;

    // Transfer kinds
    localparam logic [1:0] KIND_WR1  = 2'd0;
    localparam logic [1:0] KIND_WR2  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;
    localparam logic [1:0] KIND_ALT  = 2'd3;

    // Line phases
    localparam logic [4:0] PH_IDLE     = 5'd0;
    localparam logic [4:0] PH_ST_A     = 5'd1;
    localparam logic [4:0] PH_ST_B     = 5'd2;
    localparam logic [4:0] PH_ST_C     = 5'd3;
    localparam logic [4:0] PH_WB_LOW   = 5'd4;
    localparam logic [4:0] PH_WB_DATA  = 5'd5;
    localparam logic [4:0] PH_WB_HIGH  = 5'd6;
    localparam logic [4:0] PH_WB_END   = 5'd7;
    localparam logic [4:0] PH_WB_REL   = 5'd8;
    localparam logic [4:0] PH_ACK_HIGH = 5'd9;
    localparam logic [4:0] PH_ACK_LOW  = 5'd10;
    localparam logic [4:0] PH_RD_LOW   = 5'd11;
    localparam logic [4:0] PH_RD_REL   = 5'd12;
    localparam logic [4:0] PH_RD_HIGH  = 5'd13;
    localparam logic [4:0] PH_RD_DROP  = 5'd14;
    localparam logic [4:0] PH_RS_LOW   = 5'd15;
    localparam logic [4:0] PH_RS_DATA  = 5'd16;
    localparam logic [4:0] PH_RS_HIGH  = 5'd17;
    localparam logic [4:0] PH_RS_DROP  = 5'd18;
    localparam logic [4:0] PH_SP_A     = 5'd19;
    localparam logic [4:0] PH_SP_B     = 5'd20;
    localparam logic [4:0] PH_SP_C     = 5'd21;

    // Byte stages of a transaction
    localparam logic [2:0] SG_DEV_W  = 3'd0;
    localparam logic [2:0] SG_REG    = 3'd1;
    localparam logic [2:0] SG_DATA_A = 3'd2;
    localparam logic [2:0] SG_DATA_B = 3'd3;
    localparam logic [2:0] SG_DEV_R  = 3'd4;

    // Configuration register file contents
    typedef struct packed {
        logic [7:0]          dev_addr;
        logic [7:0]          reg_addr;
        logic [15:0]         wr_value;
        logic [1:0]          kind;
        logic [RD_LEN_W-1:0] rd_len;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic       clock_line;
        logic       data_line;
        logic       byte_ready;
        logic [7:0] read_byte;
        logic       last_byte;
        logic       busy_res;
        logic       finished;
        logic       nack_seen;
    } t_result;

endpackage
`default_nettype wire

FILE: hw/rtl/i2cm_in_if.sv
// Request channel: valid/ready handshake with begin and sampled data line.
`default_nettype none
interface i2cm_in_if;
    logic valid;
    logic ready;
    logic begin_req;
    logic sda_sample;

    modport source (output valid, output begin_req, output sda_sample, input ready);
    modport sink   (input valid, input begin_req, input sda_sample, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/i2cm_out_if.sv
// Result channel: valid/ready handshake with line levels and read data.
`default_nettype none
interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       clock_line;
    logic       data_line;
    logic       byte_ready;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       busy_res;
    logic       finished;
    logic       nack_seen;

    modport source (output valid, output clock_line, output data_line, output byte_ready,
                    output read_byte, output last_byte, output busy_res, output finished,
                    output nack_seen, input ready);
    modport sink   (input valid, input clock_line, input data_line, input byte_ready,
                    input read_byte, input last_byte, input busy_res, input finished,
                    input nack_seen, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/i2cm_seq.sv
// Bus sequencer: one line phase per step, with its state registers.
`default_nettype none
module i2cm_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic             i_begin,
    input  wire logic             i_sda,
    input  wire i2cm_pkg::t_cfg   i_cfg,
    output i2cm_pkg::t_result     o_res
);
    import i2cm_pkg::*;

    logic [4:0]          r_phase, n_phase;
    logic [3:0]          r_bit, n_bit;
    logic [7:0]          r_shift, n_shift;
    logic [RD_LEN_W-1:0] r_left, n_left;
    logic                r_nack, n_nack;
    logic                r_clk_lvl, n_clk_lvl;
    logic                r_dat_lvl, n_dat_lvl;
    logic [2:0]          r_stage, n_stage;
    logic [7:0]          r_lat_dev, n_lat_dev;
    logic [7:0]          r_lat_reg, n_lat_reg;
    logic [15:0]         r_lat_val, n_lat_val;
    logic [1:0]          r_lat_kind, n_lat_kind;

    logic                start;
    logic [4:0]          cur_phase;
    logic [3:0]          bit_inc;
    logic [7:0]          rd_shift;
    logic                rdy;
    logic [7:0]          rbyte;
    logic                last;
    logic                fin;

    // Work out one tick of the bus sequence
    always_comb begin
        n_phase    = r_phase;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_left     = r_left;
        n_nack     = r_nack;
        n_clk_lvl  = r_clk_lvl;
        n_dat_lvl  = r_dat_lvl;
        n_stage    = r_stage;
        n_lat_dev  = r_lat_dev;
        n_lat_reg  = r_lat_reg;
        n_lat_val  = r_lat_val;
        n_lat_kind = r_lat_kind;
        rdy        = 1'b0;
        rbyte      = 8'h00;
        last       = 1'b0;
        fin        = 1'b0;
        bit_inc    = r_bit + 4'd1;
        rd_shift   = {r_shift[6:0], i_sda};
        start      = (r_phase == PH_IDLE) && i_begin;
        cur_phase  = start ? PH_ST_A : r_phase;

        // Latch configuration when a transaction begins
        if (start) begin
            n_lat_dev  = i_cfg.dev_addr;
            n_lat_reg  = i_cfg.reg_addr;
            n_lat_val  = i_cfg.wr_value;
            n_lat_kind = (i_cfg.kind == KIND_ALT) ? KIND_WR1 : i_cfg.kind;
            if (i_cfg.rd_len == '0) begin
                n_left = RD_LEN_W'(1);
            end else if (i_cfg.rd_len > RD_LEN_W'(MAX_READ_BYTES)) begin
                n_left = RD_LEN_W'(MAX_READ_BYTES);
            end else begin
                n_left = i_cfg.rd_len;
            end
            n_nack  = 1'b0;
            n_stage = SG_DEV_W;
        end

        case (cur_phase)
            PH_ST_A: begin
                n_dat_lvl = 1'b1;
                n_phase   = PH_ST_B;
            end
            PH_ST_B: begin
                n_clk_lvl = 1'b1;
                n_phase   = PH_ST_C;
            end
            PH_ST_C: begin
                n_dat_lvl = 1'b0;
                n_shift   = (r_stage == SG_DEV_R) ? (r_lat_dev | 8'h01) : (r_lat_dev & 8'hfe);
                n_bit     = 4'd0;
                n_phase   = PH_WB_LOW;
            end
            PH_WB_LOW: begin
                n_clk_lvl = 1'b0;
                n_phase   = PH_WB_DATA;
            end
            PH_WB_DATA: begin
                n_dat_lvl = r_shift[7];
                n_phase   = PH_WB_HIGH;
            end
            PH_WB_HIGH: begin
                n_clk_lvl = 1'b1;
                n_shift   = {r_shift[6:0], 1'b0};
                n_bit     = bit_inc;
                n_phase   = (bit_inc >= 4'd8) ? PH_WB_END : PH_WB_LOW;
            end
            PH_WB_END: begin
                n_clk_lvl = 1'b0;
                n_phase   = PH_WB_REL;
            end
            PH_WB_REL: begin
                n_dat_lvl = 1'b1;
                n_phase   = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                n_clk_lvl = 1'b1;
                if (i_sda) begin
                    n_nack = 1'b1;
                end
                n_phase = PH_ACK_LOW;
            end
            PH_ACK_LOW: begin
                n_clk_lvl = 1'b0;
                // Pick the next byte or phase after the slave's ACK slot
                case (r_stage)
                    SG_DEV_W: begin
                        n_stage = SG_REG;
                        n_shift = r_lat_reg;
                        n_bit   = 4'd0;
                        n_phase = PH_WB_LOW;
                    end
                    SG_REG: begin
                        if (r_lat_kind == KIND_READ) begin
                            n_stage = SG_DEV_R;
                            n_phase = PH_ST_A;
                        end else begin
                            n_stage = SG_DATA_A;
                            n_shift = (r_lat_kind == KIND_WR2) ? r_lat_val[15:8]
                                                               : r_lat_val[7:0];
                            n_bit   = 4'd0;
                            n_phase = PH_WB_LOW;
                        end
                    end
                    SG_DATA_A: begin
                        if (r_lat_kind == KIND_WR2) begin
                            n_stage = SG_DATA_B;
                            n_shift = r_lat_val[7:0];
                            n_bit   = 4'd0;
                            n_phase = PH_WB_LOW;
                        end else begin
                            n_phase = PH_SP_A;
                        end
                    end
                    SG_DEV_R: begin
                        n_phase = PH_RD_LOW;
                    end
                    default: begin
                        n_phase = PH_SP_A;
                    end
                endcase
            end
            PH_RD_LOW: begin
                n_clk_lvl = 1'b0;
                n_phase   = PH_RD_REL;
            end
            PH_RD_REL: begin
                n_dat_lvl = 1'b1;
                n_shift   = 8'h00;
                n_bit     = 4'd0;
                n_phase   = PH_RD_HIGH;
            end
            PH_RD_HIGH: begin
                n_clk_lvl = 1'b1;
                n_shift   = rd_shift;
                n_bit     = bit_inc;
                // Hand out the byte once its eighth bit is in
                if (bit_inc >= 4'd8) begin
                    rdy   = 1'b1;
                    rbyte = rd_shift;
                    last  = (r_left <= RD_LEN_W'(1));
                    if (r_left != '0) begin
                        n_left = r_left - RD_LEN_W'(1);
                    end
                end
                n_phase = PH_RD_DROP;
            end
            PH_RD_DROP: begin
                n_clk_lvl = 1'b0;
                n_phase   = (r_bit >= 4'd8) ? PH_RS_LOW : PH_RD_HIGH;
            end
            PH_RS_LOW: begin
                n_clk_lvl = 1'b0;
                n_phase   = PH_RS_DATA;
            end
            PH_RS_DATA: begin
                // ACK while bytes remain, NACK after the last one
                n_dat_lvl = (r_left == '0);
                n_phase   = PH_RS_HIGH;
            end
            PH_RS_HIGH: begin
                n_clk_lvl = 1'b1;
                n_phase   = PH_RS_DROP;
            end
            PH_RS_DROP: begin
                n_clk_lvl = 1'b0;
                n_phase   = (r_left != '0) ? PH_RD_LOW : PH_SP_A;
            end
            PH_SP_A: begin
                n_dat_lvl = 1'b0;
                n_phase   = PH_SP_B;
            end
            PH_SP_B: begin
                n_clk_lvl = 1'b1;
                n_phase   = PH_SP_C;
            end
            PH_SP_C: begin
                n_dat_lvl = 1'b1;
                fin       = 1'b1;
                n_phase   = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Assemble the result of this tick
    always_comb begin
        o_res.clock_line = n_clk_lvl;
        o_res.data_line  = n_dat_lvl;
        o_res.byte_ready = rdy;
        o_res.read_byte  = rbyte;
        o_res.last_byte  = last;
        o_res.busy_res   = (n_phase != PH_IDLE);
        o_res.finished   = fin;
        o_res.nack_seen  = n_nack;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit     <= 4'd0;
            r_nack    <= 1'b0;
            r_clk_lvl <= 1'b1;
            r_dat_lvl <= 1'b1;
            r_stage   <= SG_DEV_W;
            r_left    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_nack    <= n_nack;
            r_clk_lvl <= n_clk_lvl;
            r_dat_lvl <= n_dat_lvl;
            r_stage   <= n_stage;
            r_left    <= n_left;
        end
    end

    // Shift byte and latched transaction data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift    <= 8'h00;
            r_lat_dev  <= 8'h00;
            r_lat_reg  <= 8'h00;
            r_lat_val  <= 16'h0000;
            r_lat_kind <= KIND_WR1;
        end else if (i_step) begin
            r_shift    <= n_shift;
            r_lat_dev  <= n_lat_dev;
            r_lat_reg  <= n_lat_reg;
            r_lat_val  <= n_lat_val;
            r_lat_kind <= n_lat_kind;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/i2c_master_register_access.sv
// Top level of the register-access I2C master: config, input and result stages.
`default_nettype none
`include "i2c_master_register_access_macros.svh"
// Register-access I2C master that advances the bus sequence by one line phase per
// accepted request transfer (start, device address, register address, one or two
// write bytes, or repeated start and N read bytes, then stop) and returns exactly one
// result transfer for each. A request is held in the input register, the sequencer
// steps its state as the request leaves that register and the outcome lands in the
// result register; one request is taken every cycle while results are drained, and a
// stalled result register holds the request stage and so the input. Configuration
// registers are latched at the start of each transaction and must be written
// through the plain write port while the block is idle; the block does not enforce it.
module i2c_master_register_access (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    i2cm_in_if.sink                              i_req,
    i2cm_out_if.source                           o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [i2cm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [i2cm_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import i2cm_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_vld;
    logic    r_in_begin;
    logic    r_in_sda;
    logic    r_out_vld;
    t_result r_out;
    t_result seq_res;
    logic    advance;
    logic    out_fin;
    logic    out_last;
    logic    out_byte;
    logic    out_hi;
    logic    in_hold;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr <= 8'h00;
            r_cfg.reg_addr <= 8'h00;
            r_cfg.wr_value <= 16'h0000;
            r_cfg.kind     <= KIND_WR1;
            r_cfg.rd_len   <= RD_LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEV_ADDR: r_cfg.dev_addr <= i_cfg_wdata[7:0];
                CFG_REG_ADDR: r_cfg.reg_addr <= i_cfg_wdata[7:0];
                CFG_WR_VALUE: r_cfg.wr_value <= i_cfg_wdata;
                CFG_KIND:     r_cfg.kind     <= i_cfg_wdata[1:0];
                CFG_RD_LEN:   r_cfg.rd_len   <= i_cfg_wdata[RD_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Step the sequencer when a request is held and the result slot frees up
    assign advance     = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_req.ready = !r_in_vld || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready) begin
            r_in_begin <= i_req.begin_req;
            r_in_sda   <= i_req.sda_sample;
        end
    end

    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_begin (r_in_begin),
        .i_sda   (r_in_sda),
        .i_cfg   (r_cfg),
        .o_res   (seq_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= seq_res;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.clock_line = r_out.clock_line;
    assign o_res.data_line  = r_out.data_line;
    assign o_res.byte_ready = r_out.byte_ready;
    assign o_res.read_byte  = r_out.read_byte;
    assign o_res.last_byte  = r_out.last_byte;
    assign o_res.busy_res   = r_out.busy_res;
    assign o_res.finished   = r_out.finished;
    assign o_res.nack_seen  = r_out.nack_seen;

    // Qualify the held result and request for the checks
    assign out_fin  = r_out_vld && r_out.finished;
    assign out_last = r_out_vld && r_out.last_byte;
    assign out_byte = r_out_vld && r_out.byte_ready;
    assign out_hi   = r_out.clock_line && r_out.busy_res;
    assign in_hold  = r_in_vld && !advance;

    // Checks on the sequencer and the stages
    `I2CM_ASSERT_SAME(a_fin_not_busy, out_fin, !r_out.busy_res, "finished while still busy")
    `I2CM_ASSERT_SAME(a_last_has_byte, out_last, r_out.byte_ready, "last flag without a byte")
    `I2CM_ASSERT_SAME(a_byte_on_clk_high, out_byte, out_hi, "read byte off a high clock")
    `I2CM_ASSERT_NEXT(a_hold_request, in_hold, r_in_vld, "held request dropped before its step")

endmodule
`default_nettype wire
